@@ rtl/vff_pkg.sv @@
// ============================================================================
// vff_pkg
// Shared types, step codes and saturation helpers for the viscous face flux.
// ============================================================================
package vff_pkg;

    localparam int N_KIN = 10;
    localparam int KW    = 48;   // kinematic / flux width
    localparam int MUW   = 40;   // viscosity width, Q0.40
    localparam int DW    = 32;   // distance width
    localparam int WW    = 33;   // weight width, up to 2^32
    localparam int OPW   = 66;   // multiplier operand width, signed
    localparam int PRW   = 131;  // multiplier product width, signed
    localparam int XW    = 132;  // work width after shifts and negation
    localparam int MU_FRAC = 40;
    localparam int W_BITS  = 32;

    // floor(n / 3) = (n * DIV3_MAGIC) >> 65 for any 64-bit unsigned n
    localparam logic [63:0] DIV3_MAGIC = 64'hAAAA_AAAA_AAAA_AAAB;
    localparam int DIV3_SHIFT = 65;

    typedef logic [4:0] step_t;

    localparam step_t STP_AVG0  = 5'd0;
    localparam step_t STP_AVG9  = 5'd9;
    localparam step_t STP_AVGMU = 5'd10;
    localparam step_t STP_COMB  = 5'd11;
    localparam step_t STP_MUA   = 5'd12;
    localparam step_t STP_DIV3A = 5'd13;
    localparam step_t STP_MUS2  = 5'd14;
    localparam step_t STP_MUS3  = 5'd15;
    localparam step_t STP_AU    = 5'd16;
    localparam step_t STP_DIV3T = 5'd17;
    localparam step_t STP_S2V   = 5'd18;
    localparam step_t STP_S3W   = 5'd19;
    localparam step_t STP_SUM   = 5'd20;
    localparam step_t STP_MUQ   = 5'd21;

    typedef struct packed {
        logic  load_left;
        logic  load_right;
        logic  div_start;
        logic  exec;
        logic  wb;
        logic  out_load;
        step_t step;
    } cmd_t;

    typedef struct packed {
        logic div_done;
        logic mul_done;
    } stat_t;

    function automatic logic signed [63:0] sat64(input logic signed [XW-1:0] v);
        logic signed [63:0] r;
        if ((&v[XW-1:63]) || !(|v[XW-1:63]))
            r = v[63:0];
        else if (v[XW-1])
            r = {1'b1, {63{1'b0}}};
        else
            r = {1'b0, {63{1'b1}}};
        return r;
    endfunction

    function automatic logic signed [KW-1:0] sat48(input logic signed [XW-1:0] v);
        logic signed [KW-1:0] r;
        if ((&v[XW-1:KW-1]) || !(|v[XW-1:KW-1]))
            r = v[KW-1:0];
        else if (v[XW-1])
            r = {1'b1, {(KW-1){1'b0}}};
        else
            r = {1'b0, {(KW-1){1'b1}}};
        return r;
    endfunction

endpackage

@@ rtl/vff_div.sv @@
// ============================================================================
// vff_div
// Restoring divider for the left weight, floor(dr * 2^32 / (dl + dr)).
// ============================================================================
module vff_div
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic [vff_pkg::DW-1:0]   dist_l,
    input  logic [vff_pkg::DW-1:0]   dist_r,
    output logic                     done,
    output logic [vff_pkg::WW-1:0]   wl
);

    logic [vff_pkg::DW:0]   sum_reg;
    logic [vff_pkg::DW:0]   rem_reg;
    logic [vff_pkg::DW:0]   bits_reg;
    logic [vff_pkg::WW-1:0] q_reg;
    logic [5:0]             cnt_reg;
    logic                   busy_reg;
    logic                   done_reg;

    logic [vff_pkg::DW:0]   sum_next;
    logic [vff_pkg::DW+1:0] trial;
    logic                   fits;

    assign sum_next = {1'b0, dist_l} + {1'b0, dist_r};
    assign trial    = {rem_reg, bits_reg[vff_pkg::DW]};
    assign fits     = trial >= {1'b0, sum_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                cnt_reg <= '0;
                if (sum_next == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    busy_reg <= 1'b1;
                end
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 6'd1;
                if (cnt_reg == 6'(vff_pkg::WW - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // quotient fits 33 bits, so the upper dividend bits collapse to dr >> 1
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            sum_reg  <= sum_next;
            rem_reg  <= {2'b0, dist_r[vff_pkg::DW-1:1]};
            bits_reg <= {dist_r[0], {vff_pkg::DW{1'b0}}};
            q_reg    <= (sum_next == '0) ? vff_pkg::WW'(64'd1 << (vff_pkg::W_BITS - 1))
                                         : '0;
        end
        else if (busy_reg)
        begin
            rem_reg  <= fits ? (vff_pkg::DW+1)'(trial - {1'b0, sum_reg})
                             : trial[vff_pkg::DW:0];
            bits_reg <= {bits_reg[vff_pkg::DW-1:0], 1'b0};
            q_reg    <= {q_reg[vff_pkg::WW-2:0], fits};
        end
    end

    assign done = done_reg;
    assign wl   = q_reg;

endmodule

@@ rtl/vff_mul.sv @@
// ============================================================================
// vff_mul
// Shared signed multiplier, sign-magnitude, one 16-bit digit per cycle.
// ============================================================================
module vff_mul
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    input  logic signed [vff_pkg::OPW-1:0]  op_a,
    input  logic signed [vff_pkg::OPW-1:0]  op_b,
    output logic                            done,
    output logic signed [vff_pkg::PRW-1:0]  prod
);

    localparam int MW    = vff_pkg::OPW - 1;   // magnitude width
    localparam int DIG   = 16;
    localparam int NDIG  = (MW + DIG - 1) / DIG;
    localparam int BSW   = NDIG * DIG;
    localparam int AW    = 2 * MW;

    logic [MW-1:0]  mag_a_reg;
    logic [BSW-1:0] b_sh_reg;
    logic [AW-1:0]  acc_reg;
    logic           neg_reg;
    logic [2:0]     cnt_reg;
    logic           busy_reg;
    logic           done_reg;

    logic [vff_pkg::OPW-1:0] abs_a;
    logic [vff_pkg::OPW-1:0] abs_b;
    logic [MW+DIG-1:0]       part;

    assign abs_a = op_a[vff_pkg::OPW-1] ? vff_pkg::OPW'(-op_a) : op_a;
    assign abs_b = op_b[vff_pkg::OPW-1] ? vff_pkg::OPW'(-op_b) : op_b;
    assign part  = mag_a_reg * b_sh_reg[BSW-1 -: DIG];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 3'd1;
                if (cnt_reg == 3'(NDIG - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            mag_a_reg <= abs_a[MW-1:0];
            b_sh_reg  <= BSW'(abs_b[MW-1:0]);
            acc_reg   <= '0;
            neg_reg   <= op_a[vff_pkg::OPW-1] ^ op_b[vff_pkg::OPW-1];
        end
        else if (busy_reg)
        begin
            acc_reg  <= {acc_reg[AW-DIG-1:0], {DIG{1'b0}}} + AW'(part);
            b_sh_reg <= {b_sh_reg[BSW-DIG-1:0], {DIG{1'b0}}};
        end
    end

    assign done = done_reg;
    assign prod = neg_reg ? -$signed({1'b0, acc_reg}) : $signed({1'b0, acc_reg});

endmodule

@@ rtl/vff_dp.sv @@
// ============================================================================
// vff_dp
// Datapath: held left cell, captured right cell, face averages and fluxes.
// ============================================================================
module vff_dp
#(
    parameter int FRAC_BITS = 24
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  vff_pkg::cmd_t                  cmd,
    output vff_pkg::stat_t                 stat,
    input  logic [vff_pkg::KW-1:0]         in_kin [vff_pkg::N_KIN],
    input  logic [vff_pkg::MUW-1:0]        in_mu,
    input  logic [vff_pkg::DW-1:0]         in_dist,
    output logic signed [vff_pkg::KW-1:0]  res [4]
);

    localparam int KW  = vff_pkg::KW;
    localparam int XW  = vff_pkg::XW;
    localparam int OPW = vff_pkg::OPW;

    logic [KW-1:0]             hl_kin_reg [vff_pkg::N_KIN];
    logic [vff_pkg::MUW-1:0]   hl_mu_reg;
    logic [vff_pkg::DW-1:0]    hl_d_reg;
    logic [KW-1:0]             rt_kin_reg [vff_pkg::N_KIN];
    logic [vff_pkg::MUW-1:0]   rt_mu_reg;

    logic signed [KW-1:0]      k_reg [vff_pkg::N_KIN];
    logic [vff_pkg::MUW-1:0]   mu_reg;
    logic signed [KW+2:0]      a_reg;
    logic signed [KW:0]        s2_reg;
    logic signed [KW:0]        s3_reg;
    logic signed [63:0]        x_reg;
    logic signed [63:0]        t1_reg;
    logic signed [63:0]        t2_reg;
    logic signed [63:0]        t3_reg;
    logic signed [63:0]        q_reg;
    logic signed [KW-1:0]      st_reg [4];

    logic                      div_done;
    logic [vff_pkg::WW-1:0]    wl;
    logic [vff_pkg::WW-1:0]    wl_reg;
    logic                      mul_start;
    logic                      mul_done;
    logic signed [OPW-1:0]     op_a;
    logic signed [OPW-1:0]     op_b;
    logic signed [vff_pkg::PRW-1:0] prod;

    logic signed [XW-1:0]      p_x;
    logic signed [XW-1:0]      p_w;      // shifted by the weight scale
    logic signed [XW-1:0]      p_mu;     // shifted by the viscosity scale
    logic signed [XW-1:0]      p_fr;     // shifted by the velocity scale
    logic signed [XW-1:0]      quo;      // divide-by-three magnitude
    logic signed [XW-1:0]      x_mag;
    logic [3:0]                kidx;
    logic                      is_avg;

    vff_div u_div
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (cmd.div_start),
        .dist_l (hl_d_reg),
        .dist_r (in_dist),
        .done   (div_done),
        .wl     (wl)
    );

    vff_mul u_mul
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_start),
        .op_a  (op_a),
        .op_b  (op_b),
        .done  (mul_done),
        .prod  (prod)
    );

    assign stat.div_done = div_done;
    assign stat.mul_done = mul_done;

    assign is_avg    = cmd.step inside {[vff_pkg::STP_AVG0:vff_pkg::STP_AVG9]};
    assign kidx      = cmd.step[3:0];
    assign mul_start = cmd.exec && (cmd.step != vff_pkg::STP_COMB)
                       && (cmd.step != vff_pkg::STP_SUM);

    assign p_x   = XW'(prod);
    assign p_w   = p_x >>> vff_pkg::W_BITS;
    assign p_mu  = p_x >>> vff_pkg::MU_FRAC;
    assign p_fr  = p_x >>> FRAC_BITS;
    assign quo   = p_x >>> vff_pkg::DIV3_SHIFT;
    assign x_mag = x_reg[63] ? -XW'(x_reg) : XW'(x_reg);

    // operand selection
    always_comb
    begin
        op_a = '0;
        op_b = '0;
        if (is_avg)
        begin
            op_a = OPW'($signed(hl_kin_reg[kidx])) - OPW'($signed(rt_kin_reg[kidx]));
            op_b = OPW'(wl_reg);
        end
        else
        begin
            case (cmd.step)
                vff_pkg::STP_AVGMU:
                begin
                    op_a = OPW'(hl_mu_reg) - OPW'(rt_mu_reg);
                    op_b = OPW'(wl_reg);
                end
                vff_pkg::STP_MUA:
                begin
                    op_a = OPW'(mu_reg);
                    op_b = OPW'(a_reg);
                end
                vff_pkg::STP_DIV3A, vff_pkg::STP_DIV3T:
                begin
                    op_a = x_mag[OPW-1:0];
                    op_b = OPW'(vff_pkg::DIV3_MAGIC);
                end
                vff_pkg::STP_MUS2:
                begin
                    op_a = OPW'(mu_reg);
                    op_b = OPW'(s2_reg);
                end
                vff_pkg::STP_MUS3:
                begin
                    op_a = OPW'(mu_reg);
                    op_b = OPW'(s3_reg);
                end
                vff_pkg::STP_AU:
                begin
                    op_a = OPW'(a_reg);
                    op_b = OPW'(k_reg[0]);
                end
                vff_pkg::STP_S2V:
                begin
                    op_a = OPW'(s2_reg);
                    op_b = OPW'(k_reg[1]);
                end
                vff_pkg::STP_S3W:
                begin
                    op_a = OPW'(s3_reg);
                    op_b = OPW'(k_reg[2]);
                end
                vff_pkg::STP_MUQ:
                begin
                    op_a = OPW'(mu_reg);
                    op_b = OPW'(q_reg);
                end
                default:
                begin
                    op_a = '0;
                    op_b = '0;
                end
            endcase
        end
    end

    // input capture
    always_ff @(posedge clk)
    begin
        if (cmd.load_left)
        begin
            for (int i = 0; i < vff_pkg::N_KIN; i++)
                hl_kin_reg[i] <= in_kin[i];
            hl_mu_reg <= in_mu;
            hl_d_reg  <= in_dist;
        end
        if (cmd.load_right)
        begin
            for (int i = 0; i < vff_pkg::N_KIN; i++)
                rt_kin_reg[i] <= in_kin[i];
            rt_mu_reg <= in_mu;
        end
        if (div_done)
            wl_reg <= wl;
    end

    // steps without the multiplier (COMB, SUM) and multiplier write-back
    always_ff @(posedge clk)
    begin
        if (cmd.exec && cmd.step == vff_pkg::STP_COMB)
        begin
            a_reg  <= ((KW+3)'(k_reg[3]) <<< 2)
                      - ((KW+3)'(k_reg[7]) + (KW+3)'(k_reg[9])) * 2;
            s2_reg <= (KW+1)'(k_reg[6]) + (KW+1)'(k_reg[4]);
            s3_reg <= (KW+1)'(k_reg[8]) + (KW+1)'(k_reg[5]);
        end
        if (cmd.exec && cmd.step == vff_pkg::STP_SUM)
            q_reg <= vff_pkg::sat64(XW'(t1_reg) + XW'(t2_reg) + XW'(t3_reg));
        if (cmd.wb)
        begin
            if (is_avg)
                k_reg[kidx] <= KW'(XW'($signed(rt_kin_reg[kidx])) + p_w);
            else
            begin
                case (cmd.step)
                    vff_pkg::STP_AVGMU: mu_reg    <= vff_pkg::MUW'(XW'(rt_mu_reg) + p_w);
                    vff_pkg::STP_MUA:   x_reg     <= vff_pkg::sat64(p_mu);
                    vff_pkg::STP_DIV3A: st_reg[0] <= vff_pkg::sat48(x_reg[63] ? quo : -quo);
                    vff_pkg::STP_MUS2:  st_reg[1] <= vff_pkg::sat48(-p_mu);
                    vff_pkg::STP_MUS3:  st_reg[2] <= vff_pkg::sat48(-p_mu);
                    vff_pkg::STP_AU:    x_reg     <= vff_pkg::sat64(p_fr);
                    vff_pkg::STP_DIV3T: t1_reg    <= 64'(x_reg[63] ? -quo : quo);
                    vff_pkg::STP_S2V:   t2_reg    <= vff_pkg::sat64(p_fr);
                    vff_pkg::STP_S3W:   t3_reg    <= vff_pkg::sat64(p_fr);
                    vff_pkg::STP_MUQ:   st_reg[3] <= vff_pkg::sat48(-p_mu);
                    default:            x_reg     <= x_reg;
                endcase
            end
        end
    end

    // output register, loaded only when the previous result has gone
    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            for (int i = 0; i < 4; i++)
                res[i] <= st_reg[i];
        end
    end

endmodule

@@ rtl/vff_ctrl.sv @@
// ============================================================================
// vff_ctrl
// Controller: pairs left and right beats, sequences divider and multiplier.
// ============================================================================
module vff_ctrl
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_stall,
    output logic            out_valid,
    input  logic            out_stall,
    output vff_pkg::cmd_t   cmd,
    input  vff_pkg::stat_t  stat
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_DIV  = 3'd1;
    localparam logic [2:0] ST_STEP = 3'd2;
    localparam logic [2:0] ST_MULW = 3'd3;
    localparam logic [2:0] ST_DONE = 3'd4;

    logic [2:0]     state_reg;
    logic [2:0]     state_next;
    vff_pkg::step_t step_reg;
    vff_pkg::step_t step_next;
    logic           have_left_reg;
    logic           have_left_next;
    logic           out_valid_reg;
    logic           out_valid_next;
    logic           accept;
    logic           single;

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;
    assign accept    = in_valid && (state_reg == ST_IDLE);
    assign single    = (step_reg == vff_pkg::STP_COMB) || (step_reg == vff_pkg::STP_SUM);

    always_comb
    begin
        state_next     = state_reg;
        step_next      = step_reg;
        have_left_next = have_left_reg;
        out_valid_next = out_valid_reg && out_stall;
        cmd            = '0;
        cmd.step       = step_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (!have_left_reg)
                    begin
                        cmd.load_left  = 1'b1;
                        have_left_next = 1'b1;
                    end
                    else
                    begin
                        cmd.load_right = 1'b1;
                        cmd.div_start  = 1'b1;
                        have_left_next = 1'b0;
                        state_next     = ST_DIV;
                    end
                end
            end
            ST_DIV:
            begin
                if (stat.div_done)
                begin
                    step_next  = vff_pkg::STP_AVG0;
                    state_next = ST_STEP;
                end
            end
            ST_STEP:
            begin
                cmd.exec = 1'b1;
                if (single)
                    step_next = step_reg + 5'd1;
                else
                    state_next = ST_MULW;
            end
            ST_MULW:
            begin
                if (stat.mul_done)
                begin
                    cmd.wb = 1'b1;
                    if (step_reg == vff_pkg::STP_MUQ)
                        state_next = ST_DONE;
                    else
                    begin
                        step_next  = step_reg + 5'd1;
                        state_next = ST_STEP;
                    end
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    cmd.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            step_reg      <= vff_pkg::STP_AVG0;
            have_left_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            have_left_reg <= have_left_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

@@ rtl/viscous_face_flux_top.sv @@
// result: a left-cell beat is taken and gives no result; a right-cell beat gives its
// result after the weight divider (no iterations when the distance sum is zero), 20
// multiplier steps and two steps without the multiplier, then the output load; a
// stalled output holds the load back
// input: after a right-cell beat no beat is taken until its output load; the single
// shared 16-bit-digit multiplier carries all averages and flux products
// reset: rst_n clears the controller, the pairing flag and the output valid
// ============================================================================
// viscous_face_flux_top
// Viscous stress momentum and energy fluxes across one face from a left and a
// right cell beat, Q24.24 fixed point with saturation.
// ============================================================================
module viscous_face_flux_top
#(
    parameter int FRAC_BITS = 24
)
(
    input  logic                clk,
    input  logic                rst_n,
    // input channel: left cell beat, then right cell beat
    input  logic                in_valid,
    output logic                in_stall,
    input  logic signed [47:0]  vel_n,
    input  logic signed [47:0]  vel_t,
    input  logic signed [47:0]  vel_b,
    input  logic signed [47:0]  du_dn,
    input  logic signed [47:0]  du_dt,
    input  logic signed [47:0]  du_db,
    input  logic signed [47:0]  dv_dn,
    input  logic signed [47:0]  dv_dt,
    input  logic signed [47:0]  dw_dn,
    input  logic signed [47:0]  dw_db,
    input  logic [39:0]         mix_viscosity,
    input  logic [31:0]         face_distance,
    // output channel: one beat per face pair
    output logic                out_valid,
    input  logic                out_stall,
    output logic signed [47:0]  mom_flux_n,
    output logic signed [47:0]  mom_flux_t,
    output logic signed [47:0]  mom_flux_b,
    output logic signed [47:0]  energy_flux
);

    vff_pkg::cmd_t             cmd;
    vff_pkg::stat_t            stat;
    logic [vff_pkg::KW-1:0]    kin [vff_pkg::N_KIN];
    logic signed [vff_pkg::KW-1:0] res [4];

    // kinematic order: u, v, w, then the gradient terms
    assign kin[0] = vel_n;
    assign kin[1] = vel_t;
    assign kin[2] = vel_b;
    assign kin[3] = du_dn;
    assign kin[4] = du_dt;
    assign kin[5] = du_db;
    assign kin[6] = dv_dn;
    assign kin[7] = dv_dt;
    assign kin[8] = dw_dn;
    assign kin[9] = dw_db;

    // sequencing of the pair and the shared units
    vff_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd),
        .stat      (stat)
    );

    // storage, weight divider, shared multiplier and result registers
    vff_dp #(
        .FRAC_BITS (FRAC_BITS)
    ) u_dp (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd),
        .stat    (stat),
        .in_kin  (kin),
        .in_mu   (mix_viscosity),
        .in_dist (face_distance),
        .res     (res)
    );

    assign mom_flux_n  = res[0];
    assign mom_flux_t  = res[1];
    assign mom_flux_b  = res[2];
    assign energy_flux = res[3];

endmodule
